FILE: src/sparse_row_gray_signature_macros.svh
// assertion macros for the sparse row gray signature block
`ifndef SPARSE_ROW_GRAY_SIGNATURE_MACROS_SVH
`define SPARSE_ROW_GRAY_SIGNATURE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked outside reset
`define SRGS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("srgs same-cycle check failed");
// next-cycle implication, checked outside reset
`define SRGS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("srgs next-cycle check failed");
`else
`define SRGS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SRGS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/srgs_pkg.sv
// shared types, constants and helpers of the sparse row gray signature block
`default_nettype none

package srgs_pkg;

	// field and storage sizes
	localparam int MAX_BUCKETS = 64;
	localparam int BKT_W       = $clog2(MAX_BUCKETS);
	localparam int NB_W        = $clog2(MAX_BUCKETS) + 1;
	localparam int COL_W       = 24;
	localparam int ROW_W       = 24;
	localparam int CNT_W       = 25;
	localparam int GRAY_W      = MAX_BUCKETS;

	// stream payload widths, padded to whole bytes
	localparam int S_TDATA_W = ((COL_W + ROW_W + 7) / 8) * 8;
	localparam int S_PAD_W   = S_TDATA_W - COL_W - ROW_W;
	localparam int M_TDATA_W = ((ROW_W + GRAY_W + CNT_W + 7) / 8) * 8;
	localparam int M_PAD_W   = M_TDATA_W - ROW_W - GRAY_W - CNT_W;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 25;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_PER_BUCKET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARSE_LIMIT    = 2'd2;

	localparam logic [COL_W-1:0] RST_COLS_PER_BUCKET = COL_W'(1);
	localparam logic [NB_W-1:0]  RST_BUCKET_COUNT    = NB_W'(MAX_BUCKETS);
	localparam logic [CNT_W-1:0] RST_SPARSE_LIMIT    = CNT_W'(8);

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [BKT_W-1:0] bucket;
		logic [ROW_W-1:0] row;
		logic             has_entry;
		logic             row_end;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic sweeping;
		logic holding;
	} bk_stat_t;

	// buckets in use: zero acts as one, large values cap at the maximum
	function automatic logic [NB_W-1:0] active_buckets(input logic [NB_W-1:0] bc);
		logic [NB_W-1:0] r;
		r = bc;
		if (bc == '0)
			r = NB_W'(1);
		else if (bc > NB_W'(MAX_BUCKETS))
			r = NB_W'(MAX_BUCKETS);
		return r;
	endfunction

	// saturating counter step
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + CNT_W'(1);
	endfunction

endpackage

`default_nettype wire

FILE: src/srgs_front.sv
// front end: takes requests and finds each column's bucket in a pipelined divider
`default_nettype none

module srgs_front (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// column_index [23:0], row_number [47:24]
	input  wire  [srgs_pkg::S_TDATA_W-1:0]    s_tdata,
	input  wire                               s_tlast,
	// has_entry [0]
	input  wire                               s_tuser,
	input  wire  [srgs_pkg::COL_W-1:0]        cols_per_bucket,
	input  wire  [srgs_pkg::NB_W-1:0]         nb,
	output logic                              q_push,
	output srgs_pkg::q_entry_t                q_wdata,
	input  srgs_pkg::q_stat_t                 q_stat
);
	import srgs_pkg::*;

	// one range check, then one quotient bit per stage
	localparam int STAGES = BKT_W + 1;
	localparam int DIV_W  = COL_W + BKT_W;

	typedef struct packed {
		logic             valid;
		logic [COL_W-1:0] rem;
		logic [BKT_W-1:0] quo;
		logic             over;
		logic [ROW_W-1:0] row;
		logic             has_entry;
		logic             row_end;
	} div_t;

	div_t             pipe_q [STAGES+1];
	div_t             tail;
	logic [COL_W-1:0] wd;
	logic [NB_W-1:0]  nb_dec;
	logic             en;

	// stage 0 flags quotients of MAX_BUCKETS or more, later stages restore one bit each
	function automatic div_t div_step(input div_t p, input logic [COL_W-1:0] w, input int k);
		div_t            r;
		logic [DIV_W-1:0] sh;
		r = p;
		if (k == 0) begin
			sh = {{BKT_W{1'b0}}, w} << BKT_W;
			r.over = ({{BKT_W{1'b0}}, p.rem} >= sh);
		end else begin
			sh = {{BKT_W{1'b0}}, w} << (BKT_W - k);
			if (!p.over && ({{BKT_W{1'b0}}, p.rem} >= sh)) begin
				r.rem = p.rem - sh[COL_W-1:0];
				r.quo = p.quo | (BKT_W'(1) << (BKT_W - k));
			end
		end
		return r;
	endfunction

	// zero width counts as one column per bucket
	assign wd     = (cols_per_bucket == '0) ? COL_W'(1) : cols_per_bucket;
	assign nb_dec = nb - NB_W'(1);
	assign tail   = pipe_q[STAGES];

	// whole pipe holds when the tail cannot enter the queue
	assign en       = !tail.valid || !q_stat.full;
	assign s_tready = en;

	// markers with neither entry nor row end change nothing and are dropped here
	assign q_push = tail.valid && (tail.has_entry || tail.row_end) && !q_stat.full;

	// clamp to the last bucket in use
	always_comb begin
		q_wdata.row       = tail.row;
		q_wdata.has_entry = tail.has_entry;
		q_wdata.row_end   = tail.row_end;
		if (tail.over || ({1'b0, tail.quo} >= nb))
			q_wdata.bucket = nb_dec[BKT_W-1:0];
		else
			q_wdata.bucket = tail.quo;
	end

	// divider pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= STAGES; k++)
				pipe_q[k].valid <= 1'b0;
		end else if (en) begin
			pipe_q[0].valid     <= s_tvalid;
			pipe_q[0].rem       <= s_tdata[COL_W-1:0];
			pipe_q[0].quo       <= '0;
			pipe_q[0].over      <= 1'b0;
			pipe_q[0].row       <= s_tdata[COL_W+ROW_W-1:COL_W];
			pipe_q[0].has_entry <= s_tuser;
			pipe_q[0].row_end   <= s_tlast;
			for (int k = 0; k < STAGES; k++)
				pipe_q[k+1] <= div_step(pipe_q[k], wd, k);
		end
	end

endmodule

`default_nettype wire

FILE: src/srgs_fifo.sv
// short queue of bucketed requests between front and back
`default_nettype none

module srgs_fifo (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  srgs_pkg::q_entry_t wdata,
	input  wire                pop,
	output srgs_pkg::q_entry_t rdata,
	output srgs_pkg::q_stat_t  stat
);
	import srgs_pkg::*;

	q_entry_t             mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;

	assign rdata      = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + Q_CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - Q_CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

FILE: src/srgs_back.sv
// back end: bucket counters, row-end sweep and result register
`default_nettype none

module srgs_back (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire  [srgs_pkg::NB_W-1:0]       nb,
	input  wire  [srgs_pkg::CNT_W-1:0]      sparse_limit,
	input  srgs_pkg::q_entry_t              q_rdata,
	input  srgs_pkg::q_stat_t               q_stat,
	output logic                            q_pop,
	output logic                            m_tvalid,
	input  wire                             m_tready,
	// row_id [23:0], gray_rank [87:24], nonzero_count [112:88]
	output logic [srgs_pkg::M_TDATA_W-1:0]  m_tdata,
	output srgs_pkg::bk_stat_t              stat
);
	import srgs_pkg::*;

	typedef enum logic [2:0] {
		ST_RUN   = 3'b001,
		ST_SWEEP = 3'b010,
		ST_HOLD  = 3'b100
	} bk_state_t;

	bk_state_t state_q;

	// counter memory, entries without a valid bit read as zero
	logic [CNT_W-1:0]       cnt_mem [MAX_BUCKETS];
	logic [MAX_BUCKETS-1:0] vld_q;
	logic [CNT_W-1:0]       mem_rd_q;
	logic                   rd_vld_q;
	logic [BKT_W-1:0]       rd_addr;
	logic [CNT_W-1:0]       rd_data;

	// increment stage
	logic                   valid_s1;
	logic [BKT_W-1:0]       bkt_s1;
	logic                   has_s1;
	logic                   last_s1;
	logic                   fwd_s1;
	logic [CNT_W-1:0]       fwd_val_s1;
	logic [CNT_W-1:0]       cur_cnt;
	logic [CNT_W-1:0]       inc_val;
	logic                   inc_we;
	logic [CNT_W-1:0]       row_total_q;
	logic [ROW_W-1:0]       end_row_q;

	// sweep stages
	logic                   iss_q;
	logic [BKT_W-1:0]       idx_q;
	logic                   sa_valid_s1;
	logic [BKT_W-1:0]       sa_idx_s1;
	logic                   sb_valid_s2;
	logic [BKT_W-1:0]       sb_idx_s2;
	logic [CNT_W+NB_W-1:0]  prod_s2;
	logic                   acc_q;
	logic [GRAY_W-1:0]      gray_q;
	logic                   dense;
	logic                   bit_set;
	logic                   acc_next;
	logic [GRAY_W-1:0]      gray_next;
	logic                   sweep_done;

	// result register
	logic                   out_valid_q;
	logic [ROW_W-1:0]       out_row_q;
	logic [GRAY_W-1:0]      out_gray_q;
	logic [CNT_W-1:0]       out_cnt_q;
	logic                   out_free;
	logic                   out_load;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, out_cnt_q, out_gray_q, out_row_q};

	assign stat.sweeping = (state_q == ST_SWEEP);
	assign stat.holding  = (state_q == ST_HOLD);

	// take a request unless a row end is finishing its own count
	assign q_pop = (state_q == ST_RUN) && !q_stat.empty && !(valid_s1 && last_s1);

	// read port follows the queue head, or the sweep index
	assign rd_addr = (state_q == ST_SWEEP) ? idx_q : q_rdata.bucket;
	assign rd_data = rd_vld_q ? mem_rd_q : '0;

	// read-modify-write with bypass of the write issued in the read cycle
	assign cur_cnt = fwd_s1 ? fwd_val_s1 : rd_data;
	assign inc_val = sat_inc(cur_cnt);
	assign inc_we  = valid_s1 && has_s1;

	// count > total / nb is the same as count * nb > total
	assign dense    = (row_total_q > sparse_limit);
	assign bit_set  = ({1'b0, sb_idx_s2} < nb) &&
		(dense ? (prod_s2 > {{NB_W{1'b0}}, row_total_q}) : (prod_s2 != '0));
	assign acc_next = acc_q ^ bit_set;

	// sweep runs from the top bucket down, so the running xor is the gray-to-binary bit
	always_comb begin
		gray_next = gray_q;
		gray_next[sb_idx_s2] = acc_next;
	end

	assign sweep_done = sb_valid_s2 && (sb_idx_s2 == '0);
	assign out_load   = ((state_q == ST_SWEEP) && sweep_done && out_free) ||
		((state_q == ST_HOLD) && out_free);

	// counter storage
	always_ff @(posedge clk) begin
		if (inc_we)
			cnt_mem[bkt_s1] <= inc_val;
		mem_rd_q <= cnt_mem[rd_addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			bkt_s1     <= q_rdata.bucket;
			has_s1     <= q_rdata.has_entry;
			last_s1    <= q_rdata.row_end;
			fwd_s1     <= inc_we && (bkt_s1 == q_rdata.bucket);
			fwd_val_s1 <= inc_val;
			if (q_rdata.row_end)
				end_row_q <= q_rdata.row;
		end
		sa_idx_s1 <= idx_q;
		sb_idx_s2 <= sa_idx_s1;
		prod_s2   <= {{NB_W{1'b0}}, rd_data} * {{CNT_W{1'b0}}, nb};
		if (sb_valid_s2)
			gray_q <= gray_next;
		if (out_load) begin
			out_row_q  <= end_row_q;
			out_cnt_q  <= row_total_q;
			out_gray_q <= (state_q == ST_HOLD) ? gray_q : gray_next;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			vld_q       <= '0;
			rd_vld_q    <= 1'b0;
			valid_s1    <= 1'b0;
			row_total_q <= '0;
			iss_q       <= 1'b0;
			idx_q       <= '0;
			sa_valid_s1 <= 1'b0;
			sb_valid_s2 <= 1'b0;
			acc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_q    <= vld_q[rd_addr];
			valid_s1    <= q_pop;
			sa_valid_s1 <= (state_q == ST_SWEEP) && iss_q;
			sb_valid_s2 <= sa_valid_s1;

			if (inc_we)
				vld_q[bkt_s1] <= 1'b1;
			// sweep clears each entry once it has been read
			if (sa_valid_s1)
				vld_q[sa_idx_s1] <= 1'b0;

			if (q_pop && q_rdata.has_entry)
				row_total_q <= sat_inc(row_total_q);

			if (sb_valid_s2)
				acc_q <= acc_next;

			// result valid: set on load, dropped once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
				row_total_q <= '0;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_RUN: begin
					if (valid_s1 && last_s1) begin
						state_q <= ST_SWEEP;
						iss_q   <= 1'b1;
						idx_q   <= BKT_W'(MAX_BUCKETS - 1);
						acc_q   <= 1'b0;
					end
				end
				ST_SWEEP: begin
					if (iss_q) begin
						idx_q <= idx_q - BKT_W'(1);
						if (idx_q == '0)
							iss_q <= 1'b0;
					end
					if (sweep_done)
						state_q <= out_free ? ST_RUN : ST_HOLD;
				end
				ST_HOLD: begin
					if (out_free)
						state_q <= ST_RUN;
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/sparse_row_gray_signature.sv
// Sparse row gray signature, top level.
//
// Input stream s_*: one request per nonzero of a sparse row, column_index and
// row_number in s_tdata, has_entry in s_tuser, row end in s_tlast. A request with
// has_entry low and s_tlast high closes the row without counting a nonzero.
// Output stream m_*: one result per row end with row id, gray rank of the
// bucket bitmap and nonzero count.
// Config: cfg_we writes cfg_data into register cfg_index (0 columns per bucket,
// 1 bucket count, 2 sparse limit); the user must write only while the block is
// idle, which the block itself does not enforce. Throughput: one nonzero per
// cycle except while the back end sweeps or holds a result after a row end; the
// bucket divider is an 8-stage pipeline and the counter memory does a bypassed
// read-modify-write for each nonzero. Each row end holds the back end while it
// sweeps all 64 counters through the single read port, clearing them on the way.
// Reset clears the counters (valid bits), empties the queue and loads the
// register defaults. When m_tready is low the result waits in the output
// register; the front end keeps taking requests until its pipe and queue fill.
`default_nettype none

module sparse_row_gray_signature (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// column_index [23:0], row_number [47:24]
	input  wire  [srgs_pkg::S_TDATA_W-1:0]    s_tdata,
	input  wire                               s_tlast,
	// has_entry [0]
	input  wire                               s_tuser,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// row_id [23:0], gray_rank [87:24], nonzero_count [112:88]
	output logic [srgs_pkg::M_TDATA_W-1:0]    m_tdata,
	input  wire                               cfg_we,
	input  wire  [srgs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [srgs_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import srgs_pkg::*;

`include "sparse_row_gray_signature_macros.svh"

	logic [COL_W-1:0] cols_q;
	logic [NB_W-1:0]  bucket_count_q;
	logic [CNT_W-1:0] sparse_limit_q;
	logic [NB_W-1:0]  nb;

	logic     q_push;
	logic     q_pop;
	q_entry_t q_wdata;
	q_entry_t q_rdata;
	q_stat_t  q_stat;
	bk_stat_t bk_stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q         <= RST_COLS_PER_BUCKET;
			bucket_count_q <= RST_BUCKET_COUNT;
			sparse_limit_q <= RST_SPARSE_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COLS_PER_BUCKET: cols_q         <= cfg_data[COL_W-1:0];
				CFG_BUCKET_COUNT:    bucket_count_q <= cfg_data[NB_W-1:0];
				CFG_SPARSE_LIMIT:    sparse_limit_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign nb = active_buckets(bucket_count_q);

	// bucketing front end
	srgs_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.s_tuser         (s_tuser),
		.cols_per_bucket (cols_q),
		.nb              (nb),
		.q_push          (q_push),
		.q_wdata         (q_wdata),
		.q_stat          (q_stat)
	);

	// queue between the two halves
	srgs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	// counting and signature back end
	srgs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.nb           (nb),
		.sparse_limit (sparse_limit_q),
		.q_rdata      (q_rdata),
		.q_stat       (q_stat),
		.q_pop        (q_pop),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.stat         (bk_stat)
	);

	// checks
	`SRGS_ASSERT_IMP(a_q_no_overflow, clk, arst_n, q_push, !q_stat.full)
	`SRGS_ASSERT_IMP(a_q_no_underflow, clk, arst_n, q_pop, !q_stat.empty)
	`SRGS_ASSERT_IMP(a_no_pop_in_sweep, clk, arst_n, bk_stat.sweeping || bk_stat.holding, !q_pop)
	`SRGS_ASSERT_NXT(a_hold_waits, clk, arst_n, bk_stat.holding && m_tvalid && !m_tready, bk_stat.holding)

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// self-checking testbench for sparse_row_gray_signature with its own signature predictor
`timescale 1ns / 1ps

module tb_top;
	import srgs_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 160;
	localparam int HOLD_CYCLES   = 700;
	localparam int RANDOM_ITEMS  = 900;

	// one row signature as the block reports it
	typedef struct {
		logic [ROW_W-1:0]  row_id;
		logic [GRAY_W-1:0] gray_rank;
		logic [CNT_W-1:0]  nonzero_count;
	} signature_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor copy of registers and row counters
	logic [COL_W-1:0]  sh_cols_per_bucket = RST_COLS_PER_BUCKET;
	logic [6:0]        sh_bucket_count = 7'(MAX_BUCKETS);
	logic [CNT_W-1:0]  sh_sparse_limit = RST_SPARSE_LIMIT;
	logic [CNT_W-1:0]  bucket_tally [MAX_BUCKETS];
	logic [CNT_W-1:0]  row_tally = '0;
	signature_t        expected_sigs [$];

	int err_count = 0;
	int sigs_checked = 0;
	int sent_items = 0;
	int settings_written = 0;
	int input_stalls = 0;
	int cycle_count = 0;
	int burst_left = 0;
	logic steady_source = 1'b0;

	// receiver pattern state
	int hold_serial = 0;
	int hold_served = 0;
	int hold_left = 0;
	int ready_phase_left = 0;
	int stall_pct = 0;

	sparse_row_gray_signature dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		for (int i = 0; i < MAX_BUCKETS; i++) bucket_tally[i] = '0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// input stall statistics
	always @(posedge clk) begin
		if (arst_n && s_tvalid && !s_tready) input_stalls <= input_stalls + 1;
	end

	// receiver: long hold on request, otherwise stall phases of random density
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_served != hold_serial) begin
			hold_served <= hold_serial;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			if (ready_phase_left == 0) begin
				ready_phase_left <= $urandom_range(20, 80);
				case ($urandom_range(0, 3))
					0, 1: stall_pct <= 0;
					2: stall_pct <= 30;
					default: stall_pct <= 75;
				endcase
			end else begin
				ready_phase_left <= ready_phase_left - 1;
			end
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		signature_t exp_sig;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_sigs.size() == 0) begin
				$error("unexpected result: m_tdata %h", m_tdata);
				err_count++;
			end else begin
				exp_sig = expected_sigs.pop_front();
				sigs_checked++;
				if (m_tdata[ROW_W-1:0] !== exp_sig.row_id) begin
					$error("row_id: expected %h, actual %h", exp_sig.row_id,
						m_tdata[ROW_W-1:0]);
					err_count++;
				end
				if (m_tdata[ROW_W+GRAY_W-1:ROW_W] !== exp_sig.gray_rank) begin
					$error("gray_rank: expected %h, actual %h", exp_sig.gray_rank,
						m_tdata[ROW_W+GRAY_W-1:ROW_W]);
					err_count++;
				end
				if (m_tdata[ROW_W+GRAY_W+CNT_W-1:ROW_W+GRAY_W] !== exp_sig.nonzero_count) begin
					$error("nonzero_count: expected %0d, actual %0d", exp_sig.nonzero_count,
						m_tdata[ROW_W+GRAY_W+CNT_W-1:ROW_W+GRAY_W]);
					err_count++;
				end
			end
		end
	end

	// predictor: bucket one accepted request, close the row on its end
	function automatic void account_request(input logic [COL_W-1:0] col,
			input logic [ROW_W-1:0] row, input logic has_entry, input logic row_end);
		int unsigned nb;
		int unsigned width;
		int unsigned bkt;
		int unsigned threshold;
		logic [GRAY_W-1:0] bitmap;
		logic [GRAY_W-1:0] gray;
		logic acc;
		signature_t sig;
		nb = (sh_bucket_count == 0) ? 1 :
			(sh_bucket_count > MAX_BUCKETS) ? MAX_BUCKETS : sh_bucket_count;
		if (has_entry) begin
			width = (sh_cols_per_bucket == 0) ? 1 : sh_cols_per_bucket;
			bkt = col / width;
			if (bkt >= nb) bkt = nb - 1;
			if (bucket_tally[bkt] != CNT_MAX) bucket_tally[bkt] = bucket_tally[bkt] + 1'b1;
			if (row_tally != CNT_MAX) row_tally = row_tally + 1'b1;
		end
		if (row_end) begin
			threshold = 0;
			if (row_tally > sh_sparse_limit) threshold = row_tally / nb;
			bitmap = '0;
			for (int j = 0; j < nb; j++) begin
				if (bucket_tally[j] > threshold) bitmap[j] = 1'b1;
			end
			// each rank bit is the xor of the bitmap bits at and above it
			acc = 1'b0;
			for (int i = GRAY_W - 1; i >= 0; i--) begin
				acc = acc ^ bitmap[i];
				gray[i] = acc;
			end
			sig.row_id = row;
			sig.gray_rank = gray;
			sig.nonzero_count = row_tally;
			expected_sigs = {expected_sigs, sig};
			for (int j = 0; j < MAX_BUCKETS; j++) bucket_tally[j] = '0;
			row_tally = '0;
		end
	endfunction

	// send one request, with random bursts and gaps unless held steady
	task automatic send_item(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
			input logic has_entry, input logic row_end);
		if (!steady_source && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
		end
		if (burst_left > 0) burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= S_TDATA_W'({row, col});
		s_tuser <= has_entry;
		s_tlast <= row_end;
		do @(posedge clk); while (!s_tready);
		account_request(col, row, has_entry, row_end);
		if (has_entry || row_end) sent_items++;
	endtask

	// wait for all results, then for the pipeline to go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_sigs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_COLS_PER_BUCKET: sh_cols_per_bucket = val[COL_W-1:0];
			CFG_BUCKET_COUNT:    sh_bucket_count = val[6:0];
			CFG_SPARSE_LIMIT:    sh_sparse_limit = val[CNT_W-1:0];
			default: ;
		endcase
		settings_written++;
		@(posedge clk);
	endtask

	// one random row: clustered columns, some full-range ones, stray markers
	task automatic send_row(input logic [ROW_W-1:0] row_id);
		int unsigned width;
		int unsigned nb;
		int unsigned hot [3];
		int unsigned len;
		int unsigned pick;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] tag;
		logic end_on_entry;
		width = (sh_cols_per_bucket == 0) ? 1 : sh_cols_per_bucket;
		nb = (sh_bucket_count == 0) ? 1 :
			(sh_bucket_count > MAX_BUCKETS) ? MAX_BUCKETS : sh_bucket_count;
		for (int h = 0; h < 3; h++) hot[h] = $urandom_range(0, nb - 1);
		case ($urandom_range(0, 9))
			0: len = 0;
			7, 8: len = $urandom_range(13, 40);
			9: len = $urandom_range(41, 80);
			default: len = $urandom_range(1, 12);
		endcase
		end_on_entry = (len != 0) && ($urandom_range(0, 9) < 7);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(COL_W'($urandom_range(0, 24'hFFFFFF)),
					ROW_W'($urandom_range(0, 24'hFFFFFF)), 1'b0, 1'b0);
			pick = $urandom_range(0, 9);
			if (pick == 0) col = COL_W'($urandom_range(0, 24'hFFFFFF));
			else if (pick == 1) col = '1;
			else col = COL_W'(hot[$urandom_range(0, 2)] * width + $urandom_range(0, width - 1));
			tag = ($urandom_range(0, 4) == 0) ? ROW_W'($urandom_range(0, 24'hFFFFFF)) : row_id;
			if (end_on_entry && k == len - 1) send_item(col, row_id, 1'b1, 1'b1);
			else send_item(col, tag, 1'b1, 1'b0);
		end
		if (!end_on_entry)
			send_item(COL_W'($urandom_range(0, 24'hFFFFFF)), row_id, 1'b0, 1'b1);
	endtask

	// reset values: single-entry rows at both column extremes, empty row, ignored marker
	task automatic test_defaults();
		send_item('0, '0, 1'b1, 1'b1);
		send_item('1, '1, 1'b1, 1'b1);
		send_item(24'h123456, 24'h654321, 1'b0, 1'b0);
		send_item(24'h0F0F0F, 24'h5A5A5A, 1'b0, 1'b1);
		settle();
	endtask

	// zero and out-of-range register values, widest buckets, tiny buckets
	task automatic test_register_extremes();
		write_reg(CFG_COLS_PER_BUCKET, '0);
		write_reg(CFG_BUCKET_COUNT, '0);
		write_reg(CFG_SPARSE_LIMIT, '0);
		send_item(24'd5, 24'h000010, 1'b1, 1'b0);
		send_item(24'd0, 24'h000010, 1'b1, 1'b0);
		send_item(24'd7, 24'h000010, 1'b1, 1'b1);
		settle();
		write_reg(CFG_COLS_PER_BUCKET, CFG_DATA_W'(24'hFFFFFF));
		write_reg(CFG_BUCKET_COUNT, CFG_DATA_W'(127));
		write_reg(CFG_SPARSE_LIMIT, CFG_DATA_W'(25'h1000000));
		send_item('1, 24'hA00001, 1'b1, 1'b0);
		send_item(24'd1, 24'hA00001, 1'b1, 1'b0);
		send_item('0, 24'hA00001, 1'b0, 1'b1);
		settle();
		// small buckets with an index past the last one
		write_reg(CFG_COLS_PER_BUCKET, CFG_DATA_W'(4));
		write_reg(CFG_BUCKET_COUNT, CFG_DATA_W'(4));
		write_reg(CFG_SPARSE_LIMIT, CFG_DATA_W'(2));
		for (int k = 0; k < 7; k++) send_item(COL_W'(k), 24'h000777, 1'b1, 1'b0);
		send_item(24'd100, 24'h000777, 1'b1, 1'b1);
		settle();
	endtask

	// registers change while a row is open
	task automatic test_mid_row_change();
		write_reg(CFG_COLS_PER_BUCKET, CFG_DATA_W'(1));
		write_reg(CFG_BUCKET_COUNT, CFG_DATA_W'(8));
		write_reg(CFG_SPARSE_LIMIT, CFG_DATA_W'(0));
		send_item(24'd3, 24'h00BEEF, 1'b1, 1'b0);
		send_item(24'd9, 24'h00BEEF, 1'b1, 1'b0);
		settle();
		write_reg(CFG_BUCKET_COUNT, CFG_DATA_W'(16));
		write_reg(CFG_COLS_PER_BUCKET, CFG_DATA_W'(2));
		send_item(24'd9, 24'h00BEEF, 1'b1, 1'b0);
		send_item('0, 24'h00BEEF, 1'b0, 1'b1);
		settle();
	endtask

	// random rows over a series of register settings
	task automatic test_random_rows();
		int start_count;
		int phase_start;
		logic [CFG_DATA_W-1:0] val;
		start_count = sent_items;
		while (sent_items - start_count < RANDOM_ITEMS) begin
			settle();
			case ($urandom_range(0, 5))
				0: val = CFG_DATA_W'(1);
				1: val = CFG_DATA_W'(0);
				2: val = CFG_DATA_W'(24'hFFFFFF);
				3: val = CFG_DATA_W'($urandom_range(2, 16));
				4: val = CFG_DATA_W'($urandom_range(17, 4096));
				default: val = CFG_DATA_W'($urandom_range(1, 24'hFFFFFF));
			endcase
			write_reg(CFG_COLS_PER_BUCKET, val);
			case ($urandom_range(0, 5))
				0: val = CFG_DATA_W'(1);
				1: val = CFG_DATA_W'(64);
				2: val = CFG_DATA_W'(0);
				3: val = CFG_DATA_W'($urandom_range(65, 127));
				default: val = CFG_DATA_W'($urandom_range(2, 63));
			endcase
			write_reg(CFG_BUCKET_COUNT, val);
			case ($urandom_range(0, 5))
				0: val = CFG_DATA_W'(0);
				1: val = CFG_DATA_W'(8);
				2: val = CFG_DATA_W'(25'h1000000);
				3: val = CFG_DATA_W'($urandom_range(0, 25'h1FFFFFF));
				default: val = CFG_DATA_W'($urandom_range(0, 40));
			endcase
			write_reg(CFG_SPARSE_LIMIT, val);
			phase_start = sent_items;
			while (sent_items - phase_start < 120 && sent_items - start_count < RANDOM_ITEMS)
				send_row(ROW_W'($urandom_range(0, 24'hFFFFFF)));
		end
		settle();
	endtask

	// receiver holds off while short rows keep coming, so the input backs up
	task automatic test_backpressure();
		write_reg(CFG_COLS_PER_BUCKET, CFG_DATA_W'(1));
		write_reg(CFG_BUCKET_COUNT, CFG_DATA_W'(64));
		write_reg(CFG_SPARSE_LIMIT, CFG_DATA_W'(1));
		steady_source = 1'b1;
		hold_serial++;
		for (int r = 0; r < 20; r++) begin
			for (int k = 0; k < 3; k++)
				send_item(COL_W'($urandom_range(0, 63)), ROW_W'(r), 1'b1, k == 2);
		end
		steady_source = 1'b0;
		settle();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_register_extremes();
		test_mid_row_change();
		test_random_rows();
		test_backpressure();
		settle();
		$display("covered %0d requests, %0d row signatures checked, %0d register writes",
			sent_items, sigs_checked, settings_written);
		$display("input held off for %0d cycles in total", input_stalls);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
